### rtl/fss_pkg.sv
`default_nettype none

package fss_pkg;

   localparam int MAX_QUERY_CHARS = 16;
   localparam int CHAR_W          = 8;
   localparam int QUERY_LEN_W     = 5;
   localparam int QUERY_IDX_W     = 4;
   localparam int RUN_W           = 5;
   localparam int SCORE_W         = 8;
   localparam int BONUS_W         = 6;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 2;

   // front-to-back queue and result buffer sizes
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = 2;
   localparam int QUEUE_CNT_W     = 3;
   localparam int RSP_DEPTH       = 2;
   localparam int RSP_PTR_W       = 1;
   localparam int RSP_CNT_W       = 2;

   localparam logic [BONUS_W-1:0] HIT_SCORE      = 6'd1;
   localparam logic [BONUS_W-1:0] START_BONUS    = 6'd5;
   localparam logic [BONUS_W-1:0] BOUNDARY_BONUS = 6'd3;
   localparam logic [RUN_W-1:0]   RUN_MAX        = 5'd31;
   localparam logic [SCORE_W-1:0] SCORE_MAX      = 8'd255;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_LEN  = 2'd2;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              char_valid;
      logic              last_char;
   } fss_req_type;

   typedef struct packed {
      logic               matched;
      logic [SCORE_W-1:0] match_score;
   } fss_rsp_type;

   // classified beat handed from front to back
   typedef struct packed {
      logic [CHAR_W-1:0] folded_char;
      logic              is_alnum;
      logic              char_valid;
      logic              last_char;
   } fss_item_type;

   typedef struct packed {
      logic [MAX_QUERY_CHARS-1:0][CHAR_W-1:0] query_chars;
      logic [QUERY_LEN_W-1:0]                 query_length;
   } fss_cfg_type;

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

`default_nettype wire

### rtl/fuzzy_subsequence_scorer_top.sv
// Fuzzy subsequence scorer: streams one text character per input beat against a
// query of up to 16 characters set through the csr port (low word, high word,
// length), ignoring ASCII case. A beat with last_char set closes the text and
// yields one result beat (matched, match_score); other beats yield none. The block
// takes one beat per cycle while its queue has room: a classifying front stage
// feeds a 4-entry queue, and the scoring stage retires one queued beat per cycle
// into its registered state loop (query position, run, score). Results wait in a
// 2-entry buffer; a result is readable once written there from the queue head.
// The back stage stalls on a closing beat only while the result buffer is full
// and none is popped. Write the csr registers only while no text is in flight.
`default_nettype none

module fuzzy_subsequence_scorer_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                push,
   input  fss_pkg::fss_req_type               req_item,
   output logic                               full,
   output logic                               empty,
   input  wire                                pop,
   output fss_pkg::fss_rsp_type               rsp_item,
   input  wire                                csr_we,
   input  wire [fss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [fss_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fss_pkg::*;

   logic [CSR_DATA_W-1:0]  query_low_ff, query_low_in;
   logic [CSR_DATA_W-1:0]  query_high_ff, query_high_in;
   logic [QUERY_LEN_W-1:0] query_len_ff, query_len_in;
   fss_cfg_type            cfg;

   logic                   q_full, q_push, q_pop, q_empty;
   fss_item_type           q_in_item, q_head_item;

   always_comb begin
      query_low_in  = query_low_ff;
      query_high_in = query_high_ff;
      query_len_in  = query_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUERY_LOW:  query_low_in  = csr_wdata;
            CSR_QUERY_HIGH: query_high_in = csr_wdata;
            CSR_QUERY_LEN:  query_len_in  = csr_wdata[QUERY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_low_ff  <= '0;
         query_high_ff <= '0;
         query_len_ff  <= '0;
      end else begin
         query_low_ff  <= query_low_in;
         query_high_ff <= query_high_in;
         query_len_ff  <= query_len_in;
      end
   end

   assign cfg.query_chars  = {query_high_ff, query_low_ff};
   assign cfg.query_length = query_len_ff;

   fss_front u_front (
      .req_push  (push),
      .req_item  (req_item),
      .req_full  (full),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in_item)
   );

   fss_item_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (q_head_item),
      .empty     (q_empty)
   );

   fss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head_item (q_head_item),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

endmodule

`default_nettype wire

### rtl/fss_front.sv
`default_nettype none

module fss_front (
   input  wire                   req_push,
   input  fss_pkg::fss_req_type  req_item,
   output logic                  req_full,
   input  wire                   q_full,
   output logic                  q_push,
   output fss_pkg::fss_item_type q_item
);
   import fss_pkg::*;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   always_comb begin
      q_item.folded_char = fold_case(req_item.text_char);
      q_item.is_alnum    = is_alnum(req_item.text_char);
      q_item.char_valid  = req_item.char_valid;
      q_item.last_char   = req_item.last_char;
   end

endmodule

`default_nettype wire

### rtl/fss_item_queue.sv
`default_nettype none

module fss_item_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  fss_pkg::fss_item_type push_item,
   output logic                  full,
   input  wire                   pop,
   output fss_pkg::fss_item_type head_item,
   output logic                  empty
);
   import fss_pkg::*;

   fss_item_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### rtl/fss_back.sv
`default_nettype none

module fss_back (
   input  wire                   clock,
   input  wire                   reset,
   input  fss_pkg::fss_cfg_type  cfg,
   input  fss_pkg::fss_item_type head_item,
   input  wire                   q_empty,
   output logic                  q_pop,
   output fss_pkg::fss_rsp_type  rsp_item,
   output logic                  rsp_empty,
   input  wire                   rsp_pop
);
   import fss_pkg::*;

   logic [QUERY_LEN_W-1:0] query_pos_ff, query_pos_in;
   logic [RUN_W-1:0]       run_length_ff, run_length_in;
   logic [SCORE_W-1:0]     score_total_ff, score_total_in;
   logic                   prev_alnum_ff, prev_alnum_in;
   logic                   at_text_start_ff, at_text_start_in;

   fss_rsp_type            rsp_slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   rsp_wr_ff, rsp_wr_in;
   logic [RSP_PTR_W-1:0]   rsp_rd_ff, rsp_rd_in;
   logic [RSP_CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [QUERY_LEN_W-1:0] eff_len;
   logic [CHAR_W-1:0]      query_char;
   logic                   hit;
   logic [RUN_W-1:0]       run_bump;
   logic [BONUS_W-1:0]     bonus;
   logic [SCORE_W:0]       score_sum;
   logic [QUERY_LEN_W-1:0] pos_upd;
   logic [RUN_W-1:0]       run_upd;
   logic [SCORE_W-1:0]     score_upd;
   logic                   take;
   logic                   rsp_push;
   logic                   rsp_take;
   fss_rsp_type            rsp_new;

   assign eff_len = (cfg.query_length > QUERY_LEN_W'(MAX_QUERY_CHARS)) ?
                    QUERY_LEN_W'(MAX_QUERY_CHARS) : cfg.query_length;
   assign query_char = fold_case(cfg.query_chars[query_pos_ff[QUERY_IDX_W-1:0]]);
   assign hit = head_item.folded_char == query_char;

   // hold a closing beat until the result buffer has a free slot
   assign rsp_take = rsp_pop && !rsp_empty;
   assign take     = !q_empty &&
                     (!head_item.last_char ||
                      rsp_count_ff != RSP_CNT_W'(RSP_DEPTH) || rsp_take);
   assign q_pop    = take;
   assign rsp_push = take && head_item.last_char;

   always_comb begin
      run_bump = (run_length_ff < RUN_MAX) ? run_length_ff + 1'b1 : run_length_ff;
      bonus    = HIT_SCORE + BONUS_W'(run_bump);
      if (at_text_start_ff) begin
         bonus = bonus + START_BONUS;
      end else if (!prev_alnum_ff) begin
         bonus = bonus + BOUNDARY_BONUS;
      end
      score_sum = {1'b0, score_total_ff} + (SCORE_W + 1)'(bonus);

      pos_upd   = query_pos_ff;
      run_upd   = run_length_ff;
      score_upd = score_total_ff;
      if (head_item.char_valid && query_pos_ff < eff_len) begin
         if (hit) begin
            pos_upd   = query_pos_ff + 1'b1;
            run_upd   = run_bump;
            score_upd = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
         end else begin
            run_upd = '0;
         end
      end

      rsp_new.matched     = pos_upd >= eff_len;
      rsp_new.match_score = (pos_upd >= eff_len) ? score_upd : '0;

      query_pos_in     = query_pos_ff;
      run_length_in    = run_length_ff;
      score_total_in   = score_total_ff;
      prev_alnum_in    = prev_alnum_ff;
      at_text_start_in = at_text_start_ff;
      if (take) begin
         if (head_item.last_char) begin
            query_pos_in     = '0;
            run_length_in    = '0;
            score_total_in   = '0;
            prev_alnum_in    = 1'b0;
            at_text_start_in = 1'b1;
         end else begin
            query_pos_in   = pos_upd;
            run_length_in  = run_upd;
            score_total_in = score_upd;
            if (head_item.char_valid) begin
               prev_alnum_in    = head_item.is_alnum;
               at_text_start_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_wr_in    = rsp_push ? rsp_wr_ff + 1'b1 : rsp_wr_ff;
      rsp_rd_in    = rsp_take ? rsp_rd_ff + 1'b1 : rsp_rd_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_push && !rsp_take) begin
         rsp_count_in = rsp_count_ff + 1'b1;
      end else if (rsp_take && !rsp_push) begin
         rsp_count_in = rsp_count_ff - 1'b1;
      end
   end

   assign rsp_empty = rsp_count_ff == '0;
   assign rsp_item  = rsp_slot_ff[rsp_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         query_pos_ff     <= '0;
         run_length_ff    <= '0;
         score_total_ff   <= '0;
         prev_alnum_ff    <= 1'b0;
         at_text_start_ff <= 1'b1;
         rsp_wr_ff        <= '0;
         rsp_rd_ff        <= '0;
         rsp_count_ff     <= '0;
      end else begin
         query_pos_ff     <= query_pos_in;
         run_length_ff    <= run_length_in;
         score_total_ff   <= score_total_in;
         prev_alnum_ff    <= prev_alnum_in;
         at_text_start_ff <= at_text_start_in;
         rsp_wr_ff        <= rsp_wr_in;
         rsp_rd_ff        <= rsp_rd_in;
         rsp_count_ff     <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_slot_ff[rsp_wr_ff] <= rsp_new;
      end
   end

endmodule

`default_nettype wire

### dv/fss_score_checker.sv
`timescale 1ns / 100ps

module fss_score_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_push,
   input  fss_pkg::fss_req_type              req_item,
   input  wire                               full,
   input  wire                               empty,
   input  wire                               pop,
   input  fss_pkg::fss_rsp_type              rsp_item,
   input  wire                               csr_we,
   input  wire [fss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [fss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                fail_count,
   output int                                results_pending
);

   import fss_pkg::*;

   // shadow of the query registers
   logic [CSR_DATA_W-1:0]  word_low;
   logic [CSR_DATA_W-1:0]  word_high;
   logic [QUERY_LEN_W-1:0] query_len;

   // per-text scoring state
   int matched_upto;
   int hit_run;
   int score_acc;
   bit prev_word;
   bit first_char;

   fss_rsp_type awaited_scores[$];
   fss_rsp_type oldest;

   function automatic logic [CHAR_W-1:0] lower_of(input logic [CHAR_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
   endfunction

   function automatic bit word_char(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [CHAR_W-1:0] query_byte(input int idx);
      logic [2*CSR_DATA_W-1:0] both;
      both = {word_high, word_low};
      return both[idx*CHAR_W +: CHAR_W];
   endfunction

   task automatic restart_text();
      matched_upto = 0;
      hit_run      = 0;
      score_acc    = 0;
      prev_word    = 1'b0;
      first_char   = 1'b1;
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   task automatic score_beat(input fss_req_type beat);
      int span;
      int gain;
      bit done;
      span = (query_len > MAX_QUERY_CHARS) ? MAX_QUERY_CHARS : int'(query_len);
      if (beat.char_valid) begin
         if (matched_upto < span) begin
            if (lower_of(beat.text_char) == lower_of(query_byte(matched_upto))) begin
               gain = HIT_SCORE;
               if (first_char) begin
                  gain += START_BONUS;
               end else if (!prev_word) begin
                  gain += BOUNDARY_BONUS;
               end
               if (hit_run < RUN_MAX) begin
                  hit_run++;
               end
               gain += hit_run;
               score_acc += gain;
               if (score_acc > SCORE_MAX) begin
                  score_acc = SCORE_MAX;
               end
               matched_upto++;
            end else begin
               hit_run = 0;
            end
         end
         prev_word  = word_char(beat.text_char);
         first_char = 1'b0;
      end
      if (beat.last_char) begin
         done = (matched_upto >= span);
         awaited_scores.push_back('{matched: done,
                                    match_score: done ? SCORE_W'(score_acc) : '0});
         restart_text();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         word_low   = '0;
         word_high  = '0;
         query_len  = '0;
         fail_count = 0;
         awaited_scores.delete();
         restart_text();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_QUERY_LOW:  word_low  = csr_wdata;
               CSR_QUERY_HIGH: word_high = csr_wdata;
               CSR_QUERY_LEN:  query_len = csr_wdata[QUERY_LEN_W-1:0];
               default: ;
            endcase
         end
         // retire the result first: it can never belong to a beat taken at this edge
         if (pop && !empty) begin
            if (awaited_scores.size() == 0) begin
               note_mismatch("unexpected result beat, score", -1, rsp_item.match_score);
            end else begin
               oldest = awaited_scores.pop_front();
               if (rsp_item.matched !== oldest.matched) begin
                  note_mismatch("matched", oldest.matched, rsp_item.matched);
               end
               if (rsp_item.match_score !== oldest.match_score) begin
                  note_mismatch("match_score", oldest.match_score, rsp_item.match_score);
               end
            end
         end
         if (req_push && !full) begin
            score_beat(req_item);
         end
      end
      results_pending <= awaited_scores.size();
   end

endmodule

### dv/tb_fuzzy_subsequence_scorer_top.sv
`timescale 1ns / 100ps

module tb_fuzzy_subsequence_scorer_top;

   import fss_pkg::*;

   localparam int ITEM_TARGET    = 500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   fss_req_type            req_item  = '0;
   logic                   full;
   logic                   empty;
   logic                   pop       = 1'b0;
   fss_rsp_type            rsp_item;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int results_pending;
   int beats_sent   = 0;
   int idle_odds    = 0;
   bit pop_jitter   = 1'b0;
   bit steady       = 1'b0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   logic [CHAR_W-1:0] query_bytes [MAX_QUERY_CHARS];
   int                query_span = 0;
   fss_req_type       text_beats[$];

   fuzzy_subsequence_scorer_top dut (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .req_item  (req_item),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fss_score_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_item        (req_item),
      .full            (full),
      .empty           (empty),
      .pop             (pop),
      .rsp_item        (rsp_item),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall bursts unless the run has gone steady
   always @(posedge clock) begin
      if (stall_left != 0) begin
         pop        <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && pop_jitter && $urandom_range(0, 7) == 0) begin
         pop        <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CHAR_W-1:0] pick_char();
      string marks;
      marks = " -_./:";
      case ($urandom_range(0, 5))
         0:       return CHAR_W'(8'h61 + $urandom_range(0, 25));
         1:       return CHAR_W'(8'h41 + $urandom_range(0, 25));
         2:       return CHAR_W'(8'h30 + $urandom_range(0, 9));
         3:       return marks[$urandom_range(0, 5)];
         4:       return CHAR_W'(8'h80 + $urandom_range(0, 127));
         default: return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void append_char(input logic [CHAR_W-1:0] c);
      // drop a non-character beat in now and then
      if ($urandom_range(0, 11) == 0) begin
         text_beats.push_back('{text_char: CHAR_W'($urandom), char_valid: 1'b0,
                                last_char: 1'b0});
      end
      text_beats.push_back('{text_char: c, char_valid: 1'b1, last_char: 1'b0});
   endfunction

   function automatic void build_text();
      int                kind;
      int                skip;
      logic [CHAR_W-1:0] c;
      fss_req_type       closing;
      text_beats.delete();
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         repeat ($urandom_range(0, 12)) append_char(pick_char());
      end else begin
         skip = (kind == 7 && query_span != 0) ? $urandom_range(0, query_span - 1) : -1;
         for (int i = 0; i < query_span; i++) begin
            if ($urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(1, 3)) append_char(pick_char());
            end
            c = query_bytes[i];
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                $urandom_range(0, 1) == 1) begin
               c = c ^ 8'h20;
            end
            if (i != skip) begin
               append_char(c);
            end
         end
         repeat ($urandom_range(0, 3)) append_char(pick_char());
      end
      if (text_beats.size() == 0 || $urandom_range(0, 5) == 0) begin
         text_beats.push_back('{text_char: CHAR_W'($urandom), char_valid: 1'b0,
                                last_char: 1'b1});
      end else begin
         closing = text_beats.pop_back();
         closing.last_char = 1'b1;
         text_beats.push_back(closing);
      end
   endfunction

   task automatic send_beat(input fss_req_type beat);
      int gap;
      if (!steady && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, 19);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= beat;
      req_push <= 1'b1;
      beats_sent++;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_string(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) begin
         send_beat('{text_char: s[i], char_valid: 1'b1,
                     last_char: close && (i == s.len() - 1)});
      end
   endtask

   // hold the input until every result is back and the pipe has emptied
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_query(input logic [CSR_DATA_W-1:0] lo,
                                input logic [CSR_DATA_W-1:0] hi,
                                input logic [QUERY_LEN_W-1:0] len);
      logic [2*CSR_DATA_W-1:0] both;
      csr_we    <= 1'b1;
      csr_index <= CSR_QUERY_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_QUERY_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_QUERY_LEN;
      csr_wdata <= {32'($urandom), 27'($urandom), len};
      @(posedge clock);
      // spare index goes last so a decode alias would clobber the length
      if ($urandom_range(0, 2) == 0) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= {32'($urandom), 32'($urandom)};
         @(posedge clock);
      end
      csr_we <= 1'b0;
      both = {hi, lo};
      for (int i = 0; i < MAX_QUERY_CHARS; i++) begin
         query_bytes[i] = both[i*CHAR_W +: CHAR_W];
      end
      query_span = (len > MAX_QUERY_CHARS) ? MAX_QUERY_CHARS : int'(len);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0]  lo;
      logic [CSR_DATA_W-1:0]  hi;
      logic [QUERY_LEN_W-1:0] len;
      int                     phase;
      phase      = 0;
      idle_odds  = 6;
      pop_jitter = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty query after reset: empty text and a one-character text both match
      send_beat('{text_char: 8'h00, char_valid: 1'b0, last_char: 1'b1});
      send_string("Z", 1'b1);
      settle();

      // query "aB-9" plus a high byte
      program_query(64'h0000_00C1_392D_4261, '1, 5'd5);
      send_string("Ab-9", 1'b0);
      send_beat('{text_char: 8'hC1, char_valid: 1'b1, last_char: 1'b1});
      send_string("xAb", 1'b0);
      send_beat('{text_char: 8'hFF, char_valid: 1'b0, last_char: 1'b0});
      send_string("-9 ", 1'b0);
      send_beat('{text_char: 8'hE1, char_valid: 1'b1, last_char: 1'b0});
      send_beat('{text_char: 8'hC1, char_valid: 1'b1, last_char: 1'b1});
      send_string("ab", 1'b1);
      send_string("ab-9", 1'b0);
      send_beat('{text_char: 8'hC1, char_valid: 1'b1, last_char: 1'b0});
      send_string("zz", 1'b1);
      settle();

      while (beats_sent < ITEM_TARGET) begin
         for (int k = 0; k < 8; k++) begin
            lo[k*CHAR_W +: CHAR_W] = pick_char();
            hi[k*CHAR_W +: CHAR_W] = pick_char();
         end
         len = ($urandom_range(0, 4) == 0) ? QUERY_LEN_W'($urandom_range(0, 31))
                                           : QUERY_LEN_W'($urandom_range(1, 10));
         case (phase)
            0: begin
               lo  = '0;
               hi  = '0;
               len = 5'd16;
            end
            1: begin
               lo  = '1;
               hi  = '1;
               len = 5'd31;
            end
            2: len = 5'd1;
            3: len = 5'd16;
            4: len = 5'd0;
            default: ;
         endcase
         program_query(lo, hi, len);
         repeat ($urandom_range(3, 8)) begin
            if (beats_sent > ITEM_TARGET * 4 / 5) begin
               steady = 1'b1;
            end
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 4;
               default: idle_odds = 12;
            endcase
            pop_jitter = ($urandom_range(0, 2) != 0);
            build_text();
            foreach (text_beats[i]) begin
               send_beat(text_beats[i]);
            end
         end
         settle();
         phase++;
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
